// ----- rtl/idle_timeout_eviction_table_macros.svh -----
// Assertion macros for the idle-timeout eviction table.
// Used by the top level only; expects clk and arst_n in scope.
`ifndef IDLE_TIMEOUT_EVICTION_TABLE_MACROS_SVH
`define IDLE_TIMEOUT_EVICTION_TABLE_MACROS_SVH

// Implication that must hold at every rising edge outside reset.
`define ITET_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition that must never be true at a rising edge outside reset.
`define ITET_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/itet_pkg.sv -----
// Shared types and constants for the idle-timeout eviction table.
// No dependencies; imported by every module of the block.
package itet_pkg;

	localparam int NAME_W  = 32;
	localparam int TICK_W  = 32;
	localparam int LIMIT_W = 8;
	localparam int ACT_W   = 2;
	localparam int CMD_W   = 2;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd20;

	// at most this many unload words per item
	localparam int MAX_RESULTS = 32;
	localparam int RES_W       = $clog2(MAX_RESULTS + 1);

	localparam logic [ACT_W-1:0] ACT_ACCESS = 2'd0;
	localparam logic [ACT_W-1:0] ACT_SWEEP  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

	localparam logic [CMD_W-1:0] CMD_NONE   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_UNLOAD = 2'd2;

	// strobes from the sequencer to the entry store
	typedef struct packed {
		logic rd_en;
		logic key_we;
		logic stamp_we;
		logic set_used;
		logic clr_used;
	} mem_ctl_t;

endpackage

// ----- rtl/itet_store.sv -----
// Entry store: key and stamp memories with registered read, plus used flags.
// Depends on itet_pkg.
module itet_store import itet_pkg::*; #(
	parameter int CAPACITY = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mem_ctl_t                    mem_ctl,
	input  logic [$clog2(CAPACITY)-1:0] rd_addr,
	input  logic [$clog2(CAPACITY)-1:0] wr_addr,
	input  logic [$clog2(CAPACITY)-1:0] clr_addr,
	input  logic [NAME_W-1:0]           wr_key,
	input  logic [TICK_W-1:0]           wr_stamp,
	output logic [NAME_W-1:0]           rd_key_s1,
	output logic [TICK_W-1:0]           rd_stamp_s1,
	output logic                        rd_used_s1
);

	logic [NAME_W-1:0]   key_mem   [CAPACITY];
	logic [TICK_W-1:0]   stamp_mem [CAPACITY];
	logic [CAPACITY-1:0] used_q;

	always_ff @(posedge clk) begin
		if (mem_ctl.key_we) begin
			key_mem[wr_addr] <= wr_key;
		end
		if (mem_ctl.rd_en) begin
			rd_key_s1 <= key_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_ctl.stamp_we) begin
			stamp_mem[wr_addr] <= wr_stamp;
		end
		if (mem_ctl.rd_en) begin
			rd_stamp_s1 <= stamp_mem[rd_addr];
			rd_used_s1  <= used_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else begin
			if (mem_ctl.set_used) begin
				used_q[wr_addr] <= 1'b1;
			end
			if (mem_ctl.clr_used) begin
				used_q[clr_addr] <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/itet_ctrl.sv -----
// Sequencer: walks the entry store, decides loads and unloads, owns the
// tick, the idle limit and the result register. Depends on itet_pkg.
module itet_ctrl import itet_pkg::*; #(
	parameter int CAPACITY = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  logic [ACT_W-1:0]            action,
	input  logic [NAME_W-1:0]           asset_name,
	input  logic                        valid_req,
	input  logic                        auto_load,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output logic [CMD_W-1:0]            command,
	output logic [NAME_W-1:0]           result_name,
	output logic                        last,
	output logic                        table_full,
	input  logic                        cfg_we,
	input  logic [LIMIT_W-1:0]          cfg_wdata,
	output mem_ctl_t                    mem_ctl,
	output logic [$clog2(CAPACITY)-1:0] rd_addr,
	output logic [$clog2(CAPACITY)-1:0] wr_addr,
	output logic [$clog2(CAPACITY)-1:0] clr_addr,
	output logic [NAME_W-1:0]           wr_key,
	output logic [TICK_W-1:0]           wr_stamp,
	input  logic [NAME_W-1:0]           rd_key_s1,
	input  logic [TICK_W-1:0]           rd_stamp_s1,
	input  logic                        rd_used_s1
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_FINISH = 2'd2;

	logic [1:0]         state_q;
	logic [ACT_W-1:0]   action_q;
	logic [NAME_W-1:0]  name_q;
	logic               valid_q;
	logic               auto_q;
	logic [TICK_W-1:0]  tick_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [CNT_W-1:0]   rd_idx_q;
	logic               chk_valid_s1;
	logic [IDX_W-1:0]   chk_idx_s1;
	logic               found_q;
	logic [IDX_W-1:0]   found_idx_q;
	logic               free_q;
	logic [IDX_W-1:0]   free_idx_q;
	logic               pend_valid_q;
	logic [NAME_W-1:0]  pend_name_q;
	logic [RES_W-1:0]   n_q;
	logic               rsp_valid_q;
	logic [CMD_W-1:0]   command_q;
	logic [NAME_W-1:0]  result_name_q;
	logic               last_q;
	logic               table_full_q;

	logic               accept;
	logic               out_free;
	logic               is_access;
	logic               is_sweep;
	logic [TICK_W-1:0]  age;
	logic               expire;
	logic               push_scan;
	logic               adv;
	logic               issue;
	logic               scan_done;
	logic               fin;
	logic               want_ins;
	logic               do_ins;
	logic               do_refresh;
	logic               hit;
	logic               empty_slot;
	logic [CMD_W-1:0]   fin_cmd;
	logic [NAME_W-1:0]  fin_name;
	logic               fin_full;

	always_comb begin
		accept     = req_valid && (state_q == ST_IDLE);
		out_free   = !rsp_valid_q || !rsp_stall;
		is_access  = (action_q == ACT_ACCESS);
		is_sweep   = action_q inside {ACT_SWEEP, ACT_CLEAR};
		age        = tick_q - rd_stamp_s1;
		// unload this slot: cleared outright, or idle past the limit
		expire     = chk_valid_s1 && is_sweep && rd_used_s1
			&& ((action_q == ACT_CLEAR) || (age > TICK_W'(limit_q)))
			&& (n_q != RES_W'(MAX_RESULTS));
		push_scan  = expire && pend_valid_q;
		adv        = (state_q == ST_SCAN) && (!push_scan || out_free);
		issue      = adv && (rd_idx_q != CNT_W'(CAPACITY));
		scan_done  = adv && !issue && chk_valid_s1;
		hit        = chk_valid_s1 && is_access && rd_used_s1 && (rd_key_s1 == name_q);
		empty_slot = chk_valid_s1 && is_access && !rd_used_s1;
		fin        = (state_q == ST_FINISH) && out_free;
		want_ins   = !valid_q && auto_q && !found_q;
		do_ins     = fin && is_access && want_ins && free_q;
		do_refresh = fin && is_access && found_q;

		fin_cmd  = CMD_NONE;
		fin_name = '0;
		fin_full = 1'b0;
		case (action_q)
			ACT_ACCESS: begin
				if (want_ins) begin
					fin_name = name_q;
					if (free_q) begin
						fin_cmd = CMD_LOAD;
					end else begin
						fin_full = 1'b1;
					end
				end
			end
			ACT_SWEEP, ACT_CLEAR: begin
				if (pend_valid_q) begin
					fin_cmd  = CMD_UNLOAD;
					fin_name = pend_name_q;
				end
			end
			default: begin
				fin_cmd = CMD_NONE;
			end
		endcase

		mem_ctl.rd_en    = issue;
		mem_ctl.key_we   = do_ins;
		mem_ctl.stamp_we = do_ins || do_refresh;
		mem_ctl.set_used = do_ins;
		mem_ctl.clr_used = adv && expire;
	end

	assign req_stall   = (state_q != ST_IDLE);
	assign rd_addr     = rd_idx_q[IDX_W-1:0];
	assign wr_addr     = found_q ? found_idx_q : free_idx_q;
	assign clr_addr    = chk_idx_s1;
	assign wr_key      = name_q;
	assign wr_stamp    = tick_q;
	assign rsp_valid   = rsp_valid_q;
	assign command     = command_q;
	assign result_name = result_name_q;
	assign last        = last_q;
	assign table_full  = table_full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			tick_q       <= '0;
			limit_q      <= LIMIT_RESET;
			rd_idx_q     <= '0;
			chk_valid_s1 <= 1'b0;
			found_q      <= 1'b0;
			free_q       <= 1'b0;
			pend_valid_q <= 1'b0;
			n_q          <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (action inside {ACT_ACCESS, ACT_SWEEP, ACT_CLEAR}) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_SCAN: begin
					if (scan_done) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (fin && is_sweep) begin
				tick_q <= tick_q + 1'b1;
			end
			if (accept) begin
				rd_idx_q     <= '0;
				chk_valid_s1 <= 1'b0;
				found_q      <= 1'b0;
				free_q       <= 1'b0;
				pend_valid_q <= 1'b0;
				n_q          <= '0;
			end else if (adv) begin
				chk_valid_s1 <= issue;
				if (issue) begin
					rd_idx_q <= rd_idx_q + 1'b1;
				end
				if (hit) begin
					found_q <= 1'b1;
				end
				if (empty_slot) begin
					free_q <= 1'b1;
				end
				if (expire) begin
					pend_valid_q <= 1'b1;
					n_q          <= n_q + 1'b1;
				end
			end
			if ((adv && push_scan) || fin) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_q <= action;
			name_q   <= asset_name;
			valid_q  <= valid_req;
			auto_q   <= auto_load;
		end
		if (issue) begin
			chk_idx_s1 <= rd_idx_q[IDX_W-1:0];
		end
		if (adv && hit && !found_q) begin
			found_idx_q <= chk_idx_s1;
		end
		if (adv && empty_slot && !free_q) begin
			free_idx_q <= chk_idx_s1;
		end
		if (adv && expire) begin
			pend_name_q <= rd_key_s1;
		end
		if (adv && push_scan) begin
			command_q     <= CMD_UNLOAD;
			result_name_q <= pend_name_q;
			last_q        <= 1'b0;
			table_full_q  <= 1'b0;
		end else if (fin) begin
			command_q     <= fin_cmd;
			result_name_q <= fin_name;
			last_q        <= 1'b1;
			table_full_q  <= fin_full;
		end
	end

endmodule

// ----- rtl/idle_timeout_eviction_table.sv -----
// Top level of the idle-timeout eviction table: sequencer plus entry store.
// Depends on itet_pkg, itet_store, itet_ctrl and the assertion macro header.
//
//   channel  | handshake              | word
//   ---------+------------------------+--------------------------------------------
//   request  | req_valid / req_stall  | action, asset_name, valid_req, auto_load
//   result   | rsp_valid / rsp_stall  | command, result_name, last, table_full
//   config   | cfg_we                 | cfg_wdata (idle limit, no read-back)
//
// An access, sweep or clear walks ST_SCAN, then ST_FINISH: the store is read
// one slot a cycle over its single read port unless a stalled unload word holds
// the walk, the last slot is checked after its read, and ST_FINISH writes back
// and posts the final word. The unused action code goes straight to ST_FINISH.
// Reset clears the used flags at once; no clearing pass. A stalled result
// channel holds the slot walk whenever an unload word has nowhere to go.
`include "idle_timeout_eviction_table_macros.svh"

module idle_timeout_eviction_table import itet_pkg::*; #(
	parameter int CAPACITY = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [ACT_W-1:0]   action,
	input  logic [NAME_W-1:0]  asset_name,
	input  logic               valid_req,
	input  logic               auto_load,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic [CMD_W-1:0]   command,
	output logic [NAME_W-1:0]  result_name,
	output logic               last,
	output logic               table_full,
	input  logic               cfg_we,
	input  logic [LIMIT_W-1:0] cfg_wdata
);

	localparam int IDX_W = $clog2(CAPACITY);

	// store access strobes and addresses from the sequencer
	mem_ctl_t          mem_ctl;
	logic [IDX_W-1:0]  rd_addr;
	logic [IDX_W-1:0]  wr_addr;
	logic [IDX_W-1:0]  clr_addr;
	logic [NAME_W-1:0] wr_key;
	logic [TICK_W-1:0] wr_stamp;
	// registered read data for rd_addr, valid the cycle after the read is issued
	logic [NAME_W-1:0] rd_key_s1;
	logic [TICK_W-1:0] rd_stamp_s1;
	logic              rd_used_s1;

	// Walk the slots, decide the commands and keep the result register.
	itet_ctrl #(
		.CAPACITY (CAPACITY)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.action      (action),
		.asset_name  (asset_name),
		.valid_req   (valid_req),
		.auto_load   (auto_load),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.command     (command),
		.result_name (result_name),
		.last        (last),
		.table_full  (table_full),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.mem_ctl     (mem_ctl),
		.rd_addr     (rd_addr),
		.wr_addr     (wr_addr),
		.clr_addr    (clr_addr),
		.wr_key      (wr_key),
		.wr_stamp    (wr_stamp),
		.rd_key_s1   (rd_key_s1),
		.rd_stamp_s1 (rd_stamp_s1),
		.rd_used_s1  (rd_used_s1)
	);

	// Hold names, stamps and used flags.
	itet_store #(
		.CAPACITY (CAPACITY)
	) u_store (
		.clk         (clk),
		.arst_n      (arst_n),
		.mem_ctl     (mem_ctl),
		.rd_addr     (rd_addr),
		.wr_addr     (wr_addr),
		.clr_addr    (clr_addr),
		.wr_key      (wr_key),
		.wr_stamp    (wr_stamp),
		.rd_key_s1   (rd_key_s1),
		.rd_stamp_s1 (rd_stamp_s1),
		.rd_used_s1  (rd_used_s1)
	);

	// Write-back only happens after the walk, so reads never see a write in flight.
	`ITET_ASSERT_NEVER(a_no_rd_wr_overlap, mem_ctl.rd_en && (mem_ctl.key_we || mem_ctl.stamp_we), "store read and write in the same cycle")
	// Insert and unload belong to different actions.
	`ITET_ASSERT_NEVER(a_no_set_clr, mem_ctl.set_used && mem_ctl.clr_used, "slot set and cleared together")
	// A refused insert carries no command.
	`ITET_ASSERT_IMPLY(a_full_no_cmd, rsp_valid && table_full, (command == CMD_NONE) && last, "table_full word with a command")
	// Store traffic only while an item is in progress.
	`ITET_ASSERT_IMPLY(a_mem_busy, mem_ctl.rd_en || mem_ctl.stamp_we || mem_ctl.clr_used, req_stall, "store access while idle")

endmodule
